FILE: src/kpf_pkg.sv
// Package for the key prefix list filter.
// Holds item codes, mode and register codes, and the control bundles
// that go from the top level to the row of match cells.
package kpf_pkg;

    localparam logic [1:0] KIND_PREFIX_BYTE = 2'd0;
    localparam logic [1:0] KIND_PREFIX_LEN  = 2'd1;
    localparam logic [1:0] KIND_KEY_BYTE    = 2'd2;

    localparam logic [1:0] MODE_DISABLED  = 2'd0;
    localparam logic [1:0] MODE_BLACKLIST = 2'd1;
    localparam logic [1:0] MODE_WHITELIST = 2'd2;

    localparam logic CFG_FILTER_MODE    = 1'b0;
    localparam logic CFG_ACTIVE_ENTRIES = 1'b1;

    localparam int CFG_DATA_W = 5;

    // key byte broadcast to every cell
    typedef struct packed {
        logic       step;     // key item accepted
        logic       byte_en;  // item carries a byte that is compared
        logic       last;     // clear key state after this item
        logic [7:0] data;
    } key_ctl_t;

    // table write broadcast; each cell decodes entry and range itself
    typedef struct packed {
        logic       byte_we;
        logic       len_we;
        logic [3:0] entry;
        logic [4:0] position;
        logic [7:0] data;
        logic [5:0] len_raw;
    } wr_ctl_t;

endpackage

FILE: src/kpf_if.sv
// Stream interfaces for the key prefix list filter.
// Request carries table writes and key bytes; response carries the verdict.
interface kpf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] entry;
    logic [4:0] position;
    logic [7:0] data_byte;
    logic [5:0] prefix_length;
    logic       key_last;
    logic       key_empty;

    modport source (output valid, kind, entry, position, data_byte, prefix_length,
                    key_last, key_empty, input ready);
    modport sink   (input valid, kind, entry, position, data_byte, prefix_length,
                    key_last, key_empty, output ready);
endinterface

interface kpf_rsp_if;
    logic valid;
    logic ready;
    logic forbidden;
    logic prefix_found;

    modport source (output valid, forbidden, prefix_found, input ready);
    modport sink   (input valid, forbidden, prefix_found, output ready);
endinterface

FILE: src/kpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/kpf_cell.sv
// One prefix table entry: prefix bytes, length and alive bit.
// Uses kpf_pkg and kpf_ram; passes the match chain on to the next cell.
module kpf_cell #(
    parameter int IDX            = 0,
    parameter int MAX_PREFIX_LEN = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kpf_pkg::key_ctl_t        key,
    input  kpf_pkg::wr_ctl_t         wr,
    input  logic [$clog2(MAX_PREFIX_LEN+1)-1:0] key_pos,
    input  logic [$clog2(MAX_PREFIX_LEN+1)-1:0] key_pos_new,
    input  logic [(MAX_PREFIX_LEN > 1 ? $clog2(MAX_PREFIX_LEN) : 1)-1:0] rd_addr,
    input  logic [kpf_pkg::CFG_DATA_W-1:0] active_entries,
    input  logic                     match_in,
    output logic                     match_out
);

    localparam int PW = $clog2(MAX_PREFIX_LEN + 1);
    localparam int AW = MAX_PREFIX_LEN > 1 ? $clog2(MAX_PREFIX_LEN) : 1;

    logic          byte_we;
    logic [AW-1:0] waddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    rd_byte;
    logic          byp_reg, byp_next;
    logic [7:0]    byp_data_reg;
    logic [PW-1:0] len_reg, len_next;
    logic          alive_reg, alive_next;
    logic          kill;
    logic          alive_new;
    logic          enabled;

    assign byte_we = wr.byte_we && (int'(wr.entry) == IDX)
                     && (int'(wr.position) < MAX_PREFIX_LEN);
    assign waddr   = AW'(wr.position);

    kpf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PREFIX_LEN)
    ) u_bytes (
        .clk   (clk),
        .we    (byte_we),
        .waddr (waddr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // write to the byte being prefetched shows up at once
    assign byp_next = byte_we && (waddr == rd_addr);
    assign rd_byte  = byp_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        len_next = len_reg;
        if (wr.len_we && (int'(wr.entry) == IDX))
        begin
            if (int'(wr.len_raw) > MAX_PREFIX_LEN)
            begin
                len_next = PW'(MAX_PREFIX_LEN);
            end
            else
            begin
                len_next = PW'(wr.len_raw);
            end
        end
    end

    assign kill      = key.step && key.byte_en && (key_pos < len_reg) && (rd_byte != key.data);
    assign alive_new = alive_reg && !kill;
    assign enabled   = int'(active_entries) > IDX;
    assign match_out = match_in || (enabled && alive_new && (len_reg <= key_pos_new));

    always_comb
    begin
        alive_next = alive_reg;
        if (key.step)
        begin
            alive_next = key.last ? 1'b1 : alive_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= 1'b1;
            byp_reg   <= 1'b0;
        end
        else
        begin
            alive_reg <= alive_next;
            byp_reg   <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        byp_data_reg <= wr.data;
    end

endmodule

FILE: src/key_prefix_list_filter_top.sv
// Key prefix list filter: one item accepted per cycle, verdict on rsp in the
// cycle after the accepted last key item. Stall only when the verdict register
// is full and rsp.ready is low. Each cell prefetches its next prefix byte from
// its own RAM. Reset clears mode, active count and key state; table contents
// stay undefined until written, with no clearing pass.
module key_prefix_list_filter_top #(
    parameter int ENTRIES        = 16,
    parameter int MAX_PREFIX_LEN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [kpf_pkg::CFG_DATA_W-1:0] cfg_data,
    kpf_req_if.sink                        req,
    kpf_rsp_if.source                      rsp
);

    localparam int PW = $clog2(MAX_PREFIX_LEN + 1);
    localparam int AW = MAX_PREFIX_LEN > 1 ? $clog2(MAX_PREFIX_LEN) : 1;

    logic [1:0]                     mode_reg, mode_next;
    logic [kpf_pkg::CFG_DATA_W-1:0] active_reg, active_next;
    logic [PW-1:0]                  key_pos_reg, key_pos_next, key_pos_new;
    logic [AW-1:0]                  rd_addr;
    logic                           accept;
    logic                           verdict;
    logic                           found;
    logic                           forbid;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic                           forbidden_reg;
    logic                           found_reg;
    kpf_pkg::key_ctl_t              key;
    kpf_pkg::wr_ctl_t               wr;
    logic [ENTRIES:0]               chain;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        mode_next   = mode_reg;
        active_next = active_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                kpf_pkg::CFG_FILTER_MODE:    mode_next   = cfg_data[1:0];
                kpf_pkg::CFG_ACTIVE_ENTRIES: active_next = cfg_data;
                default:                     mode_next   = mode_reg;
            endcase
        end
    end

    assign key.step    = accept && (req.kind == kpf_pkg::KIND_KEY_BYTE);
    assign key.byte_en = !req.key_empty && (int'(key_pos_reg) < MAX_PREFIX_LEN);
    assign key.last    = req.key_last;
    assign key.data    = req.data_byte;

    assign wr.byte_we  = accept && (req.kind == kpf_pkg::KIND_PREFIX_BYTE);
    assign wr.len_we   = accept && (req.kind == kpf_pkg::KIND_PREFIX_LEN);
    assign wr.entry    = req.entry;
    assign wr.position = req.position;
    assign wr.data     = req.data_byte;
    assign wr.len_raw  = req.prefix_length;

    assign key_pos_new = key.byte_en ? PW'(key_pos_reg + 1'b1) : key_pos_reg;

    always_comb
    begin
        key_pos_next = key_pos_reg;
        if (key.step)
        begin
            key_pos_next = key.last ? '0 : key_pos_new;
        end
    end

    // prefetch the byte the next key item compares against
    assign rd_addr = (int'(key_pos_next) < MAX_PREFIX_LEN) ? AW'(key_pos_next) : '0;

    assign chain[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kpf_cell #(
            .IDX            (i),
            .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .key            (key),
            .wr             (wr),
            .key_pos        (key_pos_reg),
            .key_pos_new    (key_pos_new),
            .rd_addr        (rd_addr),
            .active_entries (active_reg),
            .match_in       (chain[i]),
            .match_out      (chain[i+1])
        );
    end

    assign found   = chain[ENTRIES];
    assign verdict = key.step && key.last;

    always_comb
    begin
        case (mode_reg)
            kpf_pkg::MODE_DISABLED:  forbid = 1'b0;
            kpf_pkg::MODE_BLACKLIST: forbid = found;
            default:                 forbid = !found;  // whitelist, code 3 too
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (verdict)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= kpf_pkg::MODE_DISABLED;
            active_reg    <= '0;
            key_pos_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            active_reg    <= active_next;
            key_pos_reg   <= key_pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict)
        begin
            forbidden_reg <= forbid;
            found_reg     <= found;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.forbidden    = forbidden_reg;
    assign rsp.prefix_found = found_reg;

endmodule

FILE: src/kpf_checker.sv
// Port-level checks for the key prefix list filter.
// Uses kpf_pkg; bound to key_prefix_list_filter_top.
module kpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_kind,
    input logic       req_key_last,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_forbidden
);

    logic req_acc;
    logic key_end;

    assign req_acc = req_valid && req_ready;
    assign key_end = req_acc && (req_kind == kpf_pkg::KIND_KEY_BYTE) && req_key_last;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_forbidden))
        else $error("verdict dropped or changed while stalled");

    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(key_end))
        else $error("verdict without a last key item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && !key_end && (!rsp_valid || rsp_ready) |=> !rsp_valid)
        else $error("verdict from an item that ends no key");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty output");

endmodule

bind key_prefix_list_filter_top kpf_checker u_kpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_kind      (req.kind),
    .req_key_last  (req.key_last),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_forbidden (rsp.forbidden)
);
